// ===== design/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared widths, defaults, operation and status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int KEY_WIDTH         = 32;
  localparam int PORT_PAYLOAD_W    = 32;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== design/mhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Binary min-heap of signed keys with payloads, held in one RAM.
// out_valid strobes the cycle after the accepting edge for a reject or a delete
// that empties the heap. An insert passes S_INS_RD, S_INS_CMP per level and
// S_INS_PUT once the hole reaches the root, a delete S_DEL_LAST, S_DEL_GET and
// S_DEL_CMP per level: one RAM read, compare and write per level. One command
// at a time; busy drops the cycle after the strobe. Results are never held off.
// Reset clears the state and the entry count only; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
  parameter int CAPACITY      = mhpq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = mhpq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [mhpq_pkg::KEY_WIDTH-1:0] in_key,
  input  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]  in_payload,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_removed_key,
  output logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]  out_removed_payload,
  output logic [$clog2(CAPACITY+1)-1:0]        out_occupancy,
  output logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_top_key,
  output logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]  out_top_payload,
  output logic                                 out_is_empty
);

  localparam int KW = mhpq_pkg::KEY_WIDTH;
  localparam int OW = mhpq_pkg::PORT_PAYLOAD_W;
  localparam int PW = PAYLOAD_WIDTH;
  localparam int EW = KW + PW;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_CMP  = 8'b0000_0100,
    S_INS_PUT  = 8'b0000_1000,
    S_DEL_LAST = 8'b0001_0000,
    S_DEL_GET  = 8'b0010_0000,
    S_DEL_CMP  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [EW-1:0]       mov_r, mov_nxt;
  logic [EW-1:0]       top_r, top_nxt;
  logic signed [KW-1:0] rem_key_r, rem_key_nxt;
  logic [OW-1:0]       rem_pay_r, rem_pay_nxt;
  mhpq_pkg::status_t   status_r, status_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [AW-1:0]       raddr_a, raddr_b;
  logic [AW-1:0]       raddr_a_sel;
  logic [EW-1:0]       rdata_a, rdata_b;

  logic [CW-1:0]       rd_pos;
  logic [CW:0]         rd_lc, rd_rc;
  logic [CW:0]         lc, rc;
  logic                lv, rv, take_l, take_r;
  logic signed [KW-1:0] mov_key, a_key, b_key, best_key;
  logic [CW-1:0]       up_pos;
  logic                accept;

  mhpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a_sel),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign accept  = start && (state_r == S_IDLE);
  assign mov_key = $signed(mov_r[EW-1 -: KW]);
  assign a_key   = $signed(rdata_a[EW-1 -: KW]);
  assign b_key   = $signed(rdata_b[EW-1 -: KW]);

  // children of the current sift position
  assign lc       = {pos_r, 1'b0};
  assign rc       = {pos_r, 1'b1};
  assign lv       = lc <= {1'b0, cnt_r};
  assign rv       = rc <= {1'b0, cnt_r};
  assign take_l   = lv && (a_key < mov_key);
  assign best_key = take_l ? a_key : mov_key;
  assign take_r   = rv && (b_key < best_key);
  assign up_pos   = pos_r >> 1;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    mov_nxt     = mov_r;
    rem_key_nxt = rem_key_r;
    rem_pay_nxt = rem_pay_r;
    status_nxt  = status_r;
    we          = 1'b0;
    waddr       = AW'(pos_r - CW'(1));
    wdata       = mov_r;
    raddr_a     = '0;
    rd_pos      = CW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rem_key_nxt = '0;
          rem_pay_nxt = '0;
          status_nxt  = mhpq_pkg::ST_OK;
          pos_nxt     = CW'(1);
          if (in_func == mhpq_pkg::FN_INSERT) begin
            mov_nxt = {in_key, PW'(in_payload)};
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = mhpq_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt   = cnt_r + CW'(1);
              pos_nxt   = cnt_r + CW'(1);
              state_nxt = (cnt_r == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = mhpq_pkg::ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              rem_key_nxt = $signed(top_r[EW-1 -: KW]);
              rem_pay_nxt = OW'(top_r[PW-1:0]);
              cnt_nxt     = cnt_r - CW'(1);
              state_nxt   = (cnt_r == CW'(1)) ? S_DONE : S_DEL_LAST;
            end
          end
        end
      end
      S_INS_RD: begin
        raddr_a   = AW'(up_pos - CW'(1));
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (a_key > mov_key) begin
          // move parent down into the hole
          wdata   = rdata_a;
          pos_nxt = up_pos;
          if (up_pos == CW'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            raddr_a = AW'((up_pos >> 1) - CW'(1));
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_PUT: begin
        we        = 1'b1;
        state_nxt = S_DONE;
      end
      S_DEL_LAST: begin
        raddr_a   = AW'(cnt_r);
        state_nxt = S_DEL_GET;
      end
      S_DEL_GET: begin
        mov_nxt   = rdata_a;
        rd_pos    = CW'(1);
        state_nxt = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata   = rdata_b;
          pos_nxt = CW'(rc);
          rd_pos  = CW'(rc);
        end else if (take_l) begin
          wdata   = rdata_a;
          pos_nxt = CW'(lc);
          rd_pos  = CW'(lc);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    top_nxt = (we && (waddr == '0)) ? wdata : top_r;
  end

  // child reads for sift-down
  assign rd_lc   = {rd_pos, 1'b0};
  assign rd_rc   = {rd_pos, 1'b1};
  assign raddr_b = (rd_rc <= {1'b0, cnt_r}) ? AW'(rd_rc - (CW+1)'(1)) : '0;

  always_comb begin
    raddr_a_sel = raddr_a;
    if (state_r == S_DEL_GET || state_r == S_DEL_CMP) begin
      raddr_a_sel = (rd_lc <= {1'b0, cnt_r}) ? AW'(rd_lc - (CW+1)'(1)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r     <= pos_nxt;
    mov_r     <= mov_nxt;
    top_r     <= top_nxt;
    rem_key_r <= rem_key_nxt;
    rem_pay_r <= rem_pay_nxt;
    status_r  <= status_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_status          = status_r;
  assign out_removed_key     = rem_key_r;
  assign out_removed_payload = rem_pay_r;
  assign out_occupancy       = cnt_r;
  assign out_is_empty        = (cnt_r == '0);
  assign out_top_key         = out_is_empty ? '0 : $signed(top_r[EW-1 -: KW]);
  assign out_top_payload     = out_is_empty ? '0 : OW'(top_r[PW-1:0]);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == mhpq_pkg::FN_INSERT && cnt_r == CW'(CAPACITY)
    |=> out_valid && out_status == mhpq_pkg::ST_FULL && $stable(cnt_r))
    else $error("insert into full heap not rejected");

  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == mhpq_pkg::FN_DELETE && cnt_r == '0
    |=> out_valid && out_status == mhpq_pkg::ST_EMPTY && out_is_empty)
    else $error("delete from empty heap not rejected");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !we)
    else $error("RAM write outside an operation");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result beat");

endmodule

// ===== sim/min_heap_priority_queue_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Watches the command and result beats and keeps a heap of its own in step
// with every accepted command. Each result beat is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_check #(
  parameter int HEAP_DEPTH = mhpq_pkg::CAPACITY_DEF,
  parameter int OCC_W      = $clog2(mhpq_pkg::CAPACITY_DEF + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  in_func,
  input  logic signed [mhpq_pkg::KEY_WIDTH-1:0] in_key,
  input  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   in_payload,
  input  logic                                  out_valid,
  input  logic [1:0]                            out_status,
  input  logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_removed_key,
  input  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   out_removed_payload,
  input  logic [OCC_W-1:0]                      out_occupancy,
  input  logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_top_key,
  input  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   out_top_payload,
  input  logic                                  out_is_empty,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    mhpq_pkg::status_t                      status;
    logic signed [mhpq_pkg::KEY_WIDTH-1:0]  removed_key;
    logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]    removed_payload;
    logic [OCC_W-1:0]                       occupancy;
    logic signed [mhpq_pkg::KEY_WIDTH-1:0]  top_key;
    logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]    top_payload;
    logic                                   is_empty;
  } heap_result_t;

  logic signed [mhpq_pkg::KEY_WIDTH-1:0] heap_key [1:HEAP_DEPTH];
  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   heap_data [1:HEAP_DEPTH];
  int                                    heap_count;
  heap_result_t                          expected_q [$];
  int                                    mismatches;

  assign fail_count = mismatches;

  function automatic heap_result_t apply_command(mhpq_pkg::func_t op,
                                                 logic signed [mhpq_pkg::KEY_WIDTH-1:0] key,
                                                 logic [mhpq_pkg::PORT_PAYLOAD_W-1:0] data);
    heap_result_t                          r;
    int                                    pos;
    int                                    left;
    int                                    best;
    logic                                  moved;
    logic signed [mhpq_pkg::KEY_WIDTH-1:0] tmp_key;
    logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   tmp_data;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    if (op == mhpq_pkg::FN_INSERT) begin
      if (heap_count >= HEAP_DEPTH) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_count++;
        pos = heap_count;
        while (pos > 1 && heap_key[pos / 2] > key) begin
          heap_key[pos]  = heap_key[pos / 2];
          heap_data[pos] = heap_data[pos / 2];
          pos = pos / 2;
        end
        heap_key[pos]  = key;
        heap_data[pos] = data;
      end
    end else if (heap_count == 0) begin
      r.status = mhpq_pkg::ST_EMPTY;
    end else begin
      r.removed_key     = heap_key[1];
      r.removed_payload = heap_data[1];
      heap_key[1]  = heap_key[heap_count];
      heap_data[1] = heap_data[heap_count];
      heap_count--;
      pos   = 1;
      moved = 1'b1;
      while (moved) begin
        best = pos;
        left = 2 * pos;
        if (left <= heap_count && heap_key[left] < heap_key[best]) best = left;
        if (left + 1 <= heap_count && heap_key[left + 1] < heap_key[best]) best = left + 1;
        moved = (best != pos);
        if (moved) begin
          tmp_key         = heap_key[pos];
          tmp_data        = heap_data[pos];
          heap_key[pos]   = heap_key[best];
          heap_data[pos]  = heap_data[best];
          heap_key[best]  = tmp_key;
          heap_data[best] = tmp_data;
          pos = best;
        end
      end
    end
    r.occupancy = OCC_W'(heap_count);
    r.is_empty  = (heap_count == 0);
    if (heap_count != 0) begin
      r.top_key     = heap_key[1];
      r.top_payload = heap_data[1];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      heap_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with no command outstanding", $realtime);
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("removed_key", want.removed_key, out_removed_key);
          check_field("removed_payload", want.removed_payload, out_removed_payload);
          check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
          check_field("top_key", want.top_key, out_top_key);
          check_field("top_payload", want.top_payload, out_top_payload);
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_command(mhpq_pkg::func_t'(in_func), in_key, in_payload));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== sim/min_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives insert and delete-min commands into the queue: a short directed
// sequence, then fill, mixed and drain runs with random keys and payloads
// under three sender idle rates. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_test;

  localparam int CLK_PERIOD      = 20;
  localparam int OCC_W           = $clog2(mhpq_pkg::CAPACITY_DEF + 1);
  localparam int ITEMS_PER_PHASE = 515;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic signed [mhpq_pkg::KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [mhpq_pkg::KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {
    RUN_FILL,
    RUN_MIX_UP,
    RUN_DRAIN,
    RUN_MIX_DOWN
  } run_mode_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic                                  in_func;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] in_key;
  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   in_payload;
  logic                                  out_valid;
  logic [1:0]                            out_status;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_removed_key;
  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   out_removed_payload;
  logic [OCC_W-1:0]                      out_occupancy;
  logic signed [mhpq_pkg::KEY_WIDTH-1:0] out_top_key;
  logic [mhpq_pkg::PORT_PAYLOAD_W-1:0]   out_top_payload;
  logic                                  out_is_empty;
  int                                    fail_count;
  int                                    pending;
  int                                    idle_pct;
  int unsigned                           cycle_count;

  min_heap_priority_queue i_dut (.*);

  min_heap_priority_queue_check i_check (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_command(mhpq_pkg::func_t op,
                              logic signed [mhpq_pkg::KEY_WIDTH-1:0] key,
                              logic [mhpq_pkg::PORT_PAYLOAD_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= op;
    in_key     <= key;
    in_payload <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [mhpq_pkg::KEY_WIDTH-1:0] pick_key();
    case ($urandom_range(4))
      0, 1: return $urandom;
      2: return int'($urandom_range(8)) - 4;
      3: return int'($urandom_range(2000)) - 1000;
      default: begin
        case ($urandom_range(3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic run_phase(int count);
    int        sent;
    int        run_len;
    int        insert_pct;
    run_mode_t mode;
    sent = 0;
    mode = RUN_FILL;
    while (sent < count) begin
      case (mode)
        RUN_FILL: begin
          run_len    = $urandom_range(100, 70);
          insert_pct = 97;
        end
        RUN_DRAIN: begin
          run_len    = $urandom_range(100, 70);
          insert_pct = 3;
        end
        default: begin
          run_len    = $urandom_range(60, 20);
          insert_pct = 50;
        end
      endcase
      if (run_len > count - sent) run_len = count - sent;
      repeat (run_len) begin
        send_command(($urandom_range(99) < insert_pct) ? mhpq_pkg::FN_INSERT
                                                        : mhpq_pkg::FN_DELETE,
                     pick_key(), $urandom);
      end
      sent += run_len;
      mode = (mode == RUN_MIX_DOWN) ? RUN_FILL : run_mode_t'(mode + 1);
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_func    <= mhpq_pkg::FN_INSERT;
    in_key     <= '0;
    in_payload <= '0;
    idle_pct   = 25;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_command(mhpq_pkg::FN_DELETE, KEY_MAX, '1);
    send_command(mhpq_pkg::FN_INSERT, 0, '0);
    send_command(mhpq_pkg::FN_INSERT, KEY_MAX, '1);
    send_command(mhpq_pkg::FN_INSERT, KEY_MIN, 32'h0000_0001);
    send_command(mhpq_pkg::FN_INSERT, -1, 32'h8000_0000);
    for (int i = 1; i <= 4; i++) send_command(mhpq_pkg::FN_INSERT, 7, i);
    send_command(mhpq_pkg::FN_INSERT, KEY_MIN, 32'h5a5a_a5a5);
    repeat (11) send_command(mhpq_pkg::FN_DELETE, pick_key(), $urandom);

    run_phase(ITEMS_PER_PHASE);
    idle_pct = 79;
    run_phase(ITEMS_PER_PHASE);
    idle_pct = 0;
    run_phase(ITEMS_PER_PHASE);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
